// ===== rtl/bcx_pkg.sv =====
// Package: opcodes, result word layout and shared types of the bytecode execute unit.
`timescale 1ns / 1ps

package bcx_pkg;

    localparam logic [7:0] OP_HALT  = 8'h00;
    localparam logic [7:0] OP_MOV32 = 8'h03;
    localparam logic [7:0] OP_LD8   = 8'h04;
    localparam logic [7:0] OP_LD16  = 8'h05;
    localparam logic [7:0] OP_LD32  = 8'h06;
    localparam logic [7:0] OP_ADD   = 8'h07;
    localparam logic [7:0] OP_SUB   = 8'h08;
    localparam logic [7:0] OP_MUL   = 8'h09;
    localparam logic [7:0] OP_JMP   = 8'h0a;
    localparam logic [7:0] OP_BEQ   = 8'h0b;
    localparam logic [7:0] OP_BNE   = 8'h0c;
    localparam logic [7:0] OP_BLT   = 8'h0d;
    localparam logic [7:0] OP_BGT   = 8'h0e;
    localparam logic [7:0] OP_PUSH  = 8'h0f;
    localparam logic [7:0] OP_POP   = 8'h10;
    localparam logic [7:0] OP_LDR   = 8'h11;
    localparam logic [7:0] OP_CALL  = 8'h12;
    localparam logic [7:0] OP_RET   = 8'h13;
    localparam logic [7:0] OP_MOVR  = 8'h14;
    localparam logic [7:0] OP_SHL   = 8'h15;
    localparam logic [7:0] OP_SHR   = 8'h16;
    localparam logic [7:0] OP_AND   = 8'h17;
    localparam logic [7:0] OP_OR    = 8'h18;
    localparam logic [7:0] OP_XOR   = 8'h19;
    localparam logic [7:0] OP_SUBI  = 8'h20;
    localparam logic [7:0] OP_ADDI  = 8'h21;
    localparam logic [7:0] OP_BEQI  = 8'h22;
    localparam logic [7:0] OP_BNEI  = 8'h23;
    localparam logic [7:0] OP_BLTI  = 8'h24;
    localparam logic [7:0] OP_BGTI  = 8'h25;
    localparam logic [7:0] OP_NOP   = 8'hff;

    localparam logic [7:0] LINK_REG       = 8'hfe;
    localparam logic [7:0] START_BANK_RST = 8'hf0;

    typedef enum logic [1:0] {
        K_RUN,
        K_HALT,
        K_BAD,
        K_STOP
    } t_kind;

    typedef struct packed {
        logic        we;
        logic [7:0]  addr;
        logic [31:0] data;
    } t_rf_wr;

    // packed MSB first: next_bank lands in the lowest bits
    typedef struct packed {
        logic        stack_fault;
        logic        bad_opcode;
        logic        halted;
        logic [7:0]  store_byte;
        logic [15:0] store_offset;
        logic [7:0]  store_bank;
        logic        store_valid;
        logic [15:0] next_offset;
        logic [7:0]  next_bank;
    } t_res;

    // instruction length in bytes, 0 for undefined codes
    function automatic logic [3:0] op_length(input logic [7:0] op);
        logic [3:0] len;
        unique case (op)
            OP_NOP, OP_RET:                              len = 4'd1;
            OP_POP, OP_SHL, OP_SHR:                      len = 4'd2;
            OP_ADD, OP_SUB, OP_MUL, OP_MOVR,
            OP_AND, OP_OR, OP_XOR:                       len = 4'd3;
            OP_JMP, OP_CALL:                             len = 4'd4;
            OP_LD8, OP_PUSH, OP_LDR:                     len = 4'd5;
            OP_MOV32, OP_LD16, OP_BEQ, OP_BNE, OP_BLT,
            OP_BGT, OP_SUBI, OP_ADDI:                    len = 4'd6;
            OP_LD32:                                     len = 4'd8;
            OP_BEQI, OP_BNEI, OP_BLTI, OP_BGTI:          len = 4'd9;
            default:                                     len = 4'd0;
        endcase
        return len;
    endfunction

endpackage

// ===== rtl/bcx_modc.sv =====
// Remainder of a narrow unsigned value by a constant, via reciprocal multiply and one correction.
`timescale 1ns / 1ps

module bcx_modc #(
    parameter int W = 8,
    parameter int N = 256
) (
    input  logic [W-1:0] i_v,
    output logic [W-1:0] o_r
);

    localparam int unsigned     NW = W + 1;
    localparam longint unsigned ML = (64'd1 << (2 * W)) / N;
    localparam logic [2*W:0]    MC = (2 * W + 1)'(ML);
    localparam logic [NW-1:0]   NC = NW'(N);

    logic [3*W:0]  prod;
    logic [W-1:0]  q;
    logic [NW-1:0] qn;
    logic [NW-1:0] r;

    // quotient estimate is exact or one low
    assign prod = (3 * W + 1)'(i_v) * (3 * W + 1)'(MC);
    assign q    = prod[3*W-1:2*W];
    assign qn   = NW'(q) * NC;
    assign r    = NW'(i_v) - qn;
    assign o_r  = (r >= NC) ? W'(r - NC) : W'(r);

endmodule

// ===== rtl/bcx_regfile.sv =====
// Register file: synchronous two-read memory, reset valid bits, writeback forwarding, link shadow.
`timescale 1ns / 1ps

module bcx_regfile #(
    parameter int REG_COUNT = 256
) (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_rd_en,
    input  logic [7:0]      i_ra,
    input  logic [7:0]      i_rb,
    input  bcx_pkg::t_rf_wr i_wr,
    output logic [31:0]     o_a,
    output logic [31:0]     o_b,
    output logic [31:0]     o_link
);

    localparam int         AW   = $clog2(REG_COUNT);
    localparam logic [7:0] LINK = 8'(bcx_pkg::LINK_REG % REG_COUNT);

    logic [31:0]          mem [REG_COUNT];
    logic [REG_COUNT-1:0] r_vld;
    logic [31:0]          r_rd_a;
    logic [31:0]          r_rd_b;
    logic                 r_va;
    logic                 r_vb;
    logic [7:0]           r_ra;
    logic [7:0]           r_rb;
    logic                 r_wb_we;
    logic [7:0]           r_wb_addr;
    logic [31:0]          r_wb_data;
    logic [31:0]          r_link;

    always_ff @(posedge i_clk) begin
        if (i_wr.we) begin
            mem[i_wr.addr[AW-1:0]] <= i_wr.data;
        end
        if (i_rd_en) begin
            r_rd_a <= mem[i_ra[AW-1:0]];
            r_rd_b <= mem[i_rb[AW-1:0]];
            r_va   <= r_vld[i_ra[AW-1:0]];
            r_vb   <= r_vld[i_rb[AW-1:0]];
            r_ra   <= i_ra;
            r_rb   <= i_rb;
        end
        if (i_wr.we) begin
            r_wb_addr <= i_wr.addr;
            r_wb_data <= i_wr.data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld   <= '0;
            r_wb_we <= 1'b0;
            r_link  <= '0;
        end else begin
            r_wb_we <= i_wr.we;
            if (i_wr.we) begin
                r_vld[i_wr.addr[AW-1:0]] <= 1'b1;
                if (i_wr.addr == LINK) begin
                    r_link <= i_wr.data;
                end
            end
        end
    end

    // last write covers a read issued on the same edge
    assign o_a = (r_wb_we && r_wb_addr == r_ra) ? r_wb_data : (r_va ? r_rd_a : '0);
    assign o_b = (r_wb_we && r_wb_addr == r_rb) ? r_wb_data : (r_vb ? r_rd_b : '0);
    assign o_link = r_link;

endmodule

// ===== rtl/bcx_stack.sv =====
// Push/pop stack: synchronous memory plus stack pointer with full and empty checks.
`timescale 1ns / 1ps

module bcx_stack #(
    parameter int STACK_DEPTH = 256
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_push,
    input  logic        i_pop,
    input  logic [31:0] i_data,
    output logic        o_fault,
    output logic [31:0] o_rd_data
);

    localparam int SW = $clog2(STACK_DEPTH + 1);
    localparam int AW = $clog2(STACK_DEPTH);

    logic [31:0]   mem [STACK_DEPTH];
    logic [SW-1:0] r_sp;
    logic [SW-1:0] sp_m1;
    logic          full;
    logic          empty;

    assign full    = (r_sp == SW'(STACK_DEPTH));
    assign empty   = (r_sp == '0);
    assign sp_m1   = r_sp - SW'(1);
    assign o_fault = (i_push && full) || (i_pop && empty);

    always_ff @(posedge i_clk) begin
        if (i_push && !full) begin
            mem[r_sp[AW-1:0]] <= i_data;
        end
        if (i_pop && !empty) begin
            o_rd_data <= mem[sp_m1[AW-1:0]];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_sp <= '0;
        end else if (i_push && !full) begin
            r_sp <= r_sp + SW'(1);
        end else if (i_pop && !empty) begin
            r_sp <= sp_m1;
        end
    end

endmodule

// ===== rtl/bcx_ofifo.sv =====
// Three-entry result queue between execute and the output stream.
`timescale 1ns / 1ps

module bcx_ofifo (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_push,
    input  bcx_pkg::t_res i_data,
    input  logic          i_pop,
    output logic          o_valid,
    output bcx_pkg::t_res o_data,
    output logic [1:0]    o_cnt
);

    bcx_pkg::t_res r_q [3];
    logic [1:0]    r_wp;
    logic [1:0]    r_rp;
    logic [1:0]    r_cnt;
    logic          pop;

    assign o_valid = (r_cnt != 2'd0);
    assign o_data  = r_q[r_rp];
    assign o_cnt   = r_cnt;
    assign pop     = i_pop && o_valid;

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_q[r_wp] <= i_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= '0;
            r_rp  <= '0;
            r_cnt <= '0;
        end else begin
            if (i_push) begin
                r_wp <= (r_wp == 2'd2) ? 2'd0 : r_wp + 2'd1;
            end
            if (pop) begin
                r_rp <= (r_rp == 2'd2) ? 2'd0 : r_rp + 2'd1;
            end
            r_cnt <= r_cnt + {1'b0, i_push} - {1'b0, pop};
        end
    end

endmodule

// ===== rtl/bytecode_cpu_execute_unit.sv =====
// Top level: bytecode execute unit, accept/read stage, execute stage and result queue.
`timescale 1ns / 1ps

// Executes one decoded instruction word per cycle, back to back, while the
// result queue has room. An accepted word reads its two source registers
// (and pops the stack) from synchronous memories on the accept edge; the next
// cycle executes it, writes the register file and the program counter, and
// pushes the result word into a three-entry queue, from which it is offered
// to the output stream. Throughput is one word per clock while the queue has
// room; the last register write is forwarded to the following instruction.
// Halt, stop and stack bookkeeping depend on the opcode and the stop flag and
// are settled on the accept edge. Register contents start at zero through
// per-entry valid bits, so there is no clearing pass. Writing start_bank
// (only while idle) reloads the program counter to start_bank:0 and restarts
// a halted unit; registers and stack are kept.
module bytecode_cpu_execute_unit #(
    parameter int REG_COUNT   = 256,
    parameter int STACK_DEPTH = 256,
    parameter int BANK_SIZE   = 65536,
    parameter int BANK_TOTAL  = 256
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_cfg_we,
    input  logic [7:0]  i_cfg_wdata,      // start_bank
    input  logic        i_s_axis_tvalid,
    output logic        o_s_axis_tready,
    // opcode[7:0], reg_first[15:8], reg_second[23:16], immediate[55:24],
    // target_bank[63:56], target_offset[79:64]
    input  logic [79:0] i_s_axis_tdata,
    output logic        o_m_axis_tvalid,
    input  logic        i_m_axis_tready,
    // next_bank[7:0], next_offset[23:8], store_valid[24], store_bank[32:25],
    // store_offset[48:33], store_byte[56:49], halted[57], bad_opcode[58],
    // stack_fault[59], zero[63:60]
    output logic [63:0] o_m_axis_tdata
);

    localparam logic [16:0] BSZ       = 17'(BANK_SIZE);
    localparam logic [7:0]  LAST_BANK = 8'(BANK_TOTAL - 1);
    localparam logic [7:0]  RST_BANK  = 8'(bcx_pkg::START_BANK_RST % BANK_TOTAL);
    localparam logic [7:0]  LINK      = 8'(bcx_pkg::LINK_REG % REG_COUNT);

    // ---------------- accept stage ----------------
    logic           acc;
    logic [7:0]     in_op;
    logic [7:0]     in_ra;
    logic [7:0]     in_rb;
    logic [31:0]    in_imm;
    logic [7:0]     in_tb;
    logic [15:0]    in_to;
    logic [7:0]     ra_m;
    logic [7:0]     rb_m;
    logic [7:0]     tb_m;
    logic [15:0]    to_m;
    logic [7:0]     cfg_bank;
    logic [3:0]     len0;
    bcx_pkg::t_kind kind0;
    logic           push_req;
    logic           pop_req;
    logic           stk_fault;
    logic [31:0]    stk_data;

    logic           r_stopped;
    logic           n_stopped;

    assign in_op  = i_s_axis_tdata[7:0];
    assign in_ra  = i_s_axis_tdata[15:8];
    assign in_rb  = i_s_axis_tdata[23:16];
    assign in_imm = i_s_axis_tdata[55:24];
    assign in_tb  = i_s_axis_tdata[63:56];
    assign in_to  = i_s_axis_tdata[79:64];

    assign acc = i_s_axis_tvalid && o_s_axis_tready;

    bcx_modc #(.W(8),  .N(REG_COUNT))  u_mod_ra  (.i_v(in_ra),       .o_r(ra_m));
    bcx_modc #(.W(8),  .N(REG_COUNT))  u_mod_rb  (.i_v(in_rb),       .o_r(rb_m));
    bcx_modc #(.W(8),  .N(BANK_TOTAL)) u_mod_tb  (.i_v(in_tb),       .o_r(tb_m));
    bcx_modc #(.W(16), .N(BANK_SIZE))  u_mod_to  (.i_v(in_to),       .o_r(to_m));
    bcx_modc #(.W(8),  .N(BANK_TOTAL)) u_mod_cfg (.i_v(i_cfg_wdata), .o_r(cfg_bank));

    assign len0 = bcx_pkg::op_length(in_op);

    always_comb begin
        priority if (r_stopped)               kind0 = bcx_pkg::K_STOP;
        else if (in_op == bcx_pkg::OP_HALT)   kind0 = bcx_pkg::K_HALT;
        else if (len0 == 4'd0)                kind0 = bcx_pkg::K_BAD;
        else                                  kind0 = bcx_pkg::K_RUN;
    end

    assign push_req = acc && kind0 == bcx_pkg::K_RUN && in_op == bcx_pkg::OP_PUSH;
    assign pop_req  = acc && kind0 == bcx_pkg::K_RUN && in_op == bcx_pkg::OP_POP;

    bcx_stack #(.STACK_DEPTH(STACK_DEPTH)) u_stack (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_push    (push_req),
        .i_pop     (pop_req),
        .i_data    (in_imm),
        .o_fault   (stk_fault),
        .o_rd_data (stk_data)
    );

    // halt and undefined opcodes stop on the accept edge
    always_comb begin
        n_stopped = r_stopped;
        if (i_cfg_we) begin
            n_stopped = 1'b0;
        end else if (acc && (kind0 == bcx_pkg::K_HALT || kind0 == bcx_pkg::K_BAD)) begin
            n_stopped = 1'b1;
        end
    end

    // ---------------- execute stage ----------------
    logic           r_s1_valid;
    bcx_pkg::t_kind r_s1_kind;
    logic [7:0]     r_s1_op;
    logic [7:0]     r_s1_ra;
    logic [7:0]     r_s1_rb;
    logic [31:0]    r_s1_imm;
    logic [7:0]     r_s1_tb;
    logic [15:0]    r_s1_to;
    logic [3:0]     r_s1_len;
    logic           r_s1_fault;

    always_ff @(posedge i_clk) begin
        if (acc) begin
            r_s1_kind  <= kind0;
            r_s1_op    <= in_op;
            r_s1_ra    <= ra_m;
            r_s1_rb    <= rb_m;
            r_s1_imm   <= in_imm;
            r_s1_tb    <= tb_m;
            r_s1_to    <= to_m;
            r_s1_len   <= len0;
            r_s1_fault <= stk_fault;
        end
    end

    logic [7:0]  r_pc_bank;
    logic [15:0] r_pc_off;
    logic [7:0]  n_pc_bank;
    logic [15:0] n_pc_off;

    logic [31:0]      a;
    logic [31:0]      b;
    logic [31:0]      lnk;
    bcx_pkg::t_rf_wr  wr;
    logic [7:0]       ret_bank;
    logic [15:0]      ret_off;
    logic [16:0]      off_sum;
    logic [7:0]       seq_bank;
    logic [15:0]      seq_off;
    logic             take;
    logic             is_ret;
    bcx_pkg::t_res    res;

    bcx_regfile #(.REG_COUNT(REG_COUNT)) u_regfile (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_rd_en (acc),
        .i_ra    (ra_m),
        .i_rb    (rb_m),
        .i_wr    (wr),
        .o_a     (a),
        .o_b     (b),
        .o_link  (lnk)
    );

    bcx_modc #(.W(8),  .N(BANK_TOTAL)) u_mod_rbank (.i_v(lnk[23:16]), .o_r(ret_bank));
    bcx_modc #(.W(16), .N(BANK_SIZE))  u_mod_roff  (.i_v(lnk[15:0]),  .o_r(ret_off));

    // sequential advance with carry into the next bank
    always_comb begin
        off_sum = 17'(r_pc_off) + 17'(r_s1_len);
        if (off_sum >= BSZ) begin
            seq_off  = 16'(off_sum - BSZ);
            seq_bank = (r_pc_bank == LAST_BANK) ? 8'd0 : r_pc_bank + 8'd1;
        end else begin
            seq_off  = off_sum[15:0];
            seq_bank = r_pc_bank;
        end
    end

    always_comb begin
        take    = 1'b0;
        is_ret  = 1'b0;
        wr.we   = 1'b0;
        wr.addr = r_s1_ra;
        wr.data = '0;
        res     = '0;
        unique case (r_s1_op)
            bcx_pkg::OP_MOV32: begin
                wr.we = 1'b1; wr.addr = r_s1_rb; wr.data = r_s1_imm;
            end
            bcx_pkg::OP_LD8, bcx_pkg::OP_LD16, bcx_pkg::OP_LD32, bcx_pkg::OP_LDR: begin
                res.store_valid  = 1'b1;
                res.store_bank   = r_s1_tb;
                res.store_offset = r_s1_to;
                res.store_byte   = (r_s1_op == bcx_pkg::OP_LDR) ? a[7:0] : r_s1_imm[7:0];
            end
            bcx_pkg::OP_ADD:  begin wr.we = 1'b1; wr.data = a + b; end
            bcx_pkg::OP_SUB:  begin wr.we = 1'b1; wr.data = a - b; end
            bcx_pkg::OP_MUL:  begin wr.we = 1'b1; wr.data = a * b; end
            bcx_pkg::OP_JMP:  take = 1'b1;
            bcx_pkg::OP_BEQ:  take = (a == b);
            bcx_pkg::OP_BNE:  take = (a != b);
            bcx_pkg::OP_BLT:  take = (a < b);
            bcx_pkg::OP_BGT:  take = (a > b);
            bcx_pkg::OP_POP: begin
                wr.we = !r_s1_fault; wr.data = stk_data;
            end
            bcx_pkg::OP_CALL: begin
                wr.we = 1'b1; wr.addr = LINK; wr.data = {8'd0, seq_bank, seq_off};
                take = 1'b1;
            end
            bcx_pkg::OP_RET:  is_ret = 1'b1;
            bcx_pkg::OP_MOVR: begin
                wr.we = 1'b1; wr.addr = r_s1_rb; wr.data = a;
            end
            bcx_pkg::OP_SHL: begin
                wr.we = 1'b1; wr.data = (a >= 32'd32) ? '0 : (a << a[4:0]);
            end
            bcx_pkg::OP_SHR: begin
                wr.we = 1'b1; wr.data = (a >= 32'd32) ? '0 : (a >> a[4:0]);
            end
            bcx_pkg::OP_AND:  begin wr.we = 1'b1; wr.data = a & b; end
            bcx_pkg::OP_OR:   begin wr.we = 1'b1; wr.data = a | b; end
            bcx_pkg::OP_XOR:  begin wr.we = 1'b1; wr.data = a ^ b; end
            bcx_pkg::OP_SUBI: begin wr.we = 1'b1; wr.data = a - r_s1_imm; end
            bcx_pkg::OP_ADDI: begin wr.we = 1'b1; wr.data = a + r_s1_imm; end
            bcx_pkg::OP_BEQI: take = (a == r_s1_imm);
            bcx_pkg::OP_BNEI: take = (a != r_s1_imm);
            bcx_pkg::OP_BLTI: take = (a < r_s1_imm);
            bcx_pkg::OP_BGTI: take = (a > r_s1_imm);
            default: ;
        endcase

        priority if (take) begin
            n_pc_bank = r_s1_tb;
            n_pc_off  = r_s1_to;
        end else if (is_ret) begin
            n_pc_bank = ret_bank;
            n_pc_off  = ret_off;
        end else begin
            n_pc_bank = seq_bank;
            n_pc_off  = seq_off;
        end

        if (r_s1_kind == bcx_pkg::K_RUN) begin
            res.next_bank   = n_pc_bank;
            res.next_offset = n_pc_off;
            res.stack_fault = r_s1_fault;
        end else begin
            // halt, undefined and stopped: pc holds, nothing written
            wr.we           = 1'b0;
            res             = '0;
            res.next_bank   = r_pc_bank;
            res.next_offset = r_pc_off;
            res.halted      = (r_s1_kind != bcx_pkg::K_BAD);
            res.bad_opcode  = (r_s1_kind == bcx_pkg::K_BAD);
        end

        if (!r_s1_valid) begin
            wr.we = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid <= 1'b0;
            r_stopped  <= 1'b0;
            r_pc_bank  <= RST_BANK;
            r_pc_off   <= '0;
        end else begin
            r_s1_valid <= acc;
            r_stopped  <= n_stopped;
            if (i_cfg_we) begin
                r_pc_bank <= cfg_bank;
                r_pc_off  <= '0;
            end else if (r_s1_valid && r_s1_kind == bcx_pkg::K_RUN) begin
                r_pc_bank <= n_pc_bank;
                r_pc_off  <= n_pc_off;
            end
        end
    end

    // ---------------- result queue ----------------
    // room is reserved for the word in execute, so execute never stalls
    bcx_pkg::t_res q_data;
    logic [1:0]    q_cnt;

    bcx_ofifo u_ofifo (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (r_s1_valid),
        .i_data  (res),
        .i_pop   (i_m_axis_tready),
        .o_valid (o_m_axis_tvalid),
        .o_data  (q_data),
        .o_cnt   (q_cnt)
    );

    assign o_s_axis_tready = ({1'b0, q_cnt} + {2'b00, r_s1_valid}) < 3'd3;
    assign o_m_axis_tdata  = {4'd0, q_data};

endmodule

// ===== dv/bcx_checker.sv =====
// Checker: watches the instruction and result channels, predicts results and compares them.
`timescale 1ns / 1ps

module bcx_checker (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_cfg_we,
    input  logic [7:0]  i_cfg_wdata,
    input  logic        i_in_fire,
    input  logic [79:0] i_in_word,
    input  logic        i_out_fire,
    input  logic [63:0] i_out_word,
    output int          o_errors,
    output int          o_pending,
    output int          o_results,
    output int          o_stores,
    output int          o_faults
);

    logic [31:0]   regs [256];
    logic [31:0]   stk [256];
    logic [8:0]    sp;
    logic [7:0]    pcb;
    logic [15:0]   pco;
    logic          halted_st;
    bcx_pkg::t_res expq [$];

    assign o_pending = expq.size();

    function automatic logic [3:0] instr_len(input logic [7:0] op);
        case (op)
            bcx_pkg::OP_NOP, bcx_pkg::OP_RET:                         return 4'd1;
            bcx_pkg::OP_POP, bcx_pkg::OP_SHL, bcx_pkg::OP_SHR:        return 4'd2;
            bcx_pkg::OP_ADD, bcx_pkg::OP_SUB, bcx_pkg::OP_MUL, bcx_pkg::OP_MOVR,
            bcx_pkg::OP_AND, bcx_pkg::OP_OR, bcx_pkg::OP_XOR:         return 4'd3;
            bcx_pkg::OP_JMP, bcx_pkg::OP_CALL:                        return 4'd4;
            bcx_pkg::OP_LD8, bcx_pkg::OP_PUSH, bcx_pkg::OP_LDR:       return 4'd5;
            bcx_pkg::OP_MOV32, bcx_pkg::OP_LD16, bcx_pkg::OP_BEQ, bcx_pkg::OP_BNE,
            bcx_pkg::OP_BLT, bcx_pkg::OP_BGT, bcx_pkg::OP_SUBI,
            bcx_pkg::OP_ADDI:                                         return 4'd6;
            bcx_pkg::OP_LD32:                                         return 4'd8;
            bcx_pkg::OP_BEQI, bcx_pkg::OP_BNEI, bcx_pkg::OP_BLTI,
            bcx_pkg::OP_BGTI:                                         return 4'd9;
            default:                                                  return 4'd0;
        endcase
    endfunction

    task automatic execute(input logic [79:0] w);
        logic [7:0]    op, ra, rb, tb;
        logic [31:0]   imm, a, b;
        logic [15:0]   tof;
        logic [16:0]   nsum;
        logic [7:0]    nb;
        logic [15:0]   no;
        logic [3:0]    len;
        logic          take;
        bcx_pkg::t_res r;
        op = w[7:0]; ra = w[15:8]; rb = w[23:16]; imm = w[55:24];
        tb = w[63:56]; tof = w[79:64];
        r = '0;
        take = 1'b0;
        len = instr_len(op);
        if (halted_st) begin
            r.next_bank = pcb; r.next_offset = pco; r.halted = 1'b1;
        end else if (op == bcx_pkg::OP_HALT || len == 0) begin
            halted_st = 1'b1;
            r.next_bank = pcb; r.next_offset = pco;
            r.halted = (op == bcx_pkg::OP_HALT);
            r.bad_opcode = (op != bcx_pkg::OP_HALT);
        end else begin
            nsum = {1'b0, pco} + len;
            no = nsum[15:0];
            nb = pcb + nsum[16];
            a = regs[ra];
            b = regs[rb];
            case (op)
                bcx_pkg::OP_MOV32: regs[rb] = imm;
                bcx_pkg::OP_LD8, bcx_pkg::OP_LD16, bcx_pkg::OP_LD32, bcx_pkg::OP_LDR: begin
                    r.store_valid = 1'b1; r.store_bank = tb; r.store_offset = tof;
                    r.store_byte = (op == bcx_pkg::OP_LDR) ? a[7:0] : imm[7:0];
                end
                bcx_pkg::OP_ADD:  regs[ra] = a + b;
                bcx_pkg::OP_SUB:  regs[ra] = a - b;
                bcx_pkg::OP_MUL:  regs[ra] = a * b;
                bcx_pkg::OP_JMP:  take = 1'b1;
                bcx_pkg::OP_BEQ:  take = (a == b);
                bcx_pkg::OP_BNE:  take = (a != b);
                bcx_pkg::OP_BLT:  take = (a < b);
                bcx_pkg::OP_BGT:  take = (a > b);
                bcx_pkg::OP_PUSH: begin
                    if (sp >= 256) r.stack_fault = 1'b1;
                    else begin
                        stk[sp[7:0]] = imm; sp = sp + 1;
                    end
                end
                bcx_pkg::OP_POP: begin
                    if (sp == 0) r.stack_fault = 1'b1;
                    else begin
                        sp = sp - 1; regs[ra] = stk[sp[7:0]];
                    end
                end
                bcx_pkg::OP_CALL: begin
                    regs[bcx_pkg::LINK_REG] = {8'h00, nb, no};
                    take = 1'b1;
                end
                bcx_pkg::OP_RET: begin
                    nb = regs[bcx_pkg::LINK_REG][23:16];
                    no = regs[bcx_pkg::LINK_REG][15:0];
                end
                bcx_pkg::OP_MOVR: regs[rb] = a;
                bcx_pkg::OP_SHL:  regs[ra] = (a >= 32) ? 32'd0 : a << a[4:0];
                bcx_pkg::OP_SHR:  regs[ra] = (a >= 32) ? 32'd0 : a >> a[4:0];
                bcx_pkg::OP_AND:  regs[ra] = a & b;
                bcx_pkg::OP_OR:   regs[ra] = a | b;
                bcx_pkg::OP_XOR:  regs[ra] = a ^ b;
                bcx_pkg::OP_SUBI: regs[ra] = a - imm;
                bcx_pkg::OP_ADDI: regs[ra] = a + imm;
                bcx_pkg::OP_BEQI: take = (a == imm);
                bcx_pkg::OP_BNEI: take = (a != imm);
                bcx_pkg::OP_BLTI: take = (a < imm);
                bcx_pkg::OP_BGTI: take = (a > imm);
                default: ;
            endcase
            if (take) begin
                nb = tb; no = tof;
            end
            pcb = nb; pco = no;
            r.next_bank = nb; r.next_offset = no;
        end
        expq.push_back(r);
    endtask

    always @(posedge i_clk) begin
        bcx_pkg::t_res got, want;
        if (!i_rst_n) begin
            foreach (regs[k]) regs[k] = '0;
            sp = '0;
            pcb = bcx_pkg::START_BANK_RST;
            pco = '0;
            halted_st = 1'b0;
            expq.delete();
            o_errors <= 0; o_results <= 0; o_stores <= 0; o_faults <= 0;
        end else begin
            if (i_cfg_we) begin
                pcb = i_cfg_wdata; pco = '0; halted_st = 1'b0;
            end
            if (i_in_fire) execute(i_in_word);
            if (i_out_fire) begin
                got = bcx_pkg::t_res'(i_out_word[59:0]);
                o_results <= o_results + 1;
                if (got.store_valid) o_stores <= o_stores + 1;
                if (got.stack_fault) o_faults <= o_faults + 1;
                if (expq.size() == 0) begin
                    $display("%0t: unexpected result %h", $time, i_out_word);
                    o_errors <= o_errors + 1;
                end else begin
                    want = expq.pop_front();
                    if (got !== want || i_out_word[63:60] !== 4'h0) begin
                        $display("%0t: result mismatch expected %h actual %h",
                                 $time, {4'h0, want}, i_out_word);
                        o_errors <= o_errors + 1;
                    end
                end
            end
        end
    end

endmodule

// ===== dv/testbench.sv =====
// Testbench top: clock, reset, instruction stimulus, result back-pressure and verdict.
`timescale 1ns / 1ps

module testbench;

    localparam int WATCHDOG = 5000;

    logic        clk;
    logic        rst_n;
    logic        cfg_we;
    logic [7:0]  cfg_wdata;
    logic        s_valid;
    logic        s_ready;
    logic [79:0] s_data;
    logic        m_valid;
    logic        m_ready;
    logic [63:0] m_data;

    int errors, pending, results, stores, faults;
    int words_sent;
    bit long_stall;    // receiver holds off for a long stretch while set
    int idle_cycles;

    bytecode_cpu_execute_unit u_top (
        .i_clk           (clk),
        .i_rst_n         (rst_n),
        .i_cfg_we        (cfg_we),
        .i_cfg_wdata     (cfg_wdata),
        .i_s_axis_tvalid (s_valid),
        .o_s_axis_tready (s_ready),
        .i_s_axis_tdata  (s_data),
        .o_m_axis_tvalid (m_valid),
        .i_m_axis_tready (m_ready),
        .o_m_axis_tdata  (m_data)
    );

    bcx_checker u_checker (
        .i_clk       (clk),
        .i_rst_n     (rst_n),
        .i_cfg_we    (cfg_we),
        .i_cfg_wdata (cfg_wdata),
        .i_in_fire   (s_valid && s_ready),
        .i_in_word   (s_data),
        .i_out_fire  (m_valid && m_ready),
        .i_out_word  (m_data),
        .o_errors    (errors),
        .o_pending   (pending),
        .o_results   (results),
        .o_stores    (stores),
        .o_faults    (faults)
    );

    initial begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    // watchdog: cycles without any handshake
    always @(posedge clk) begin
        if (!rst_n || (s_valid && s_ready) || (m_valid && m_ready) || cfg_we)
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= WATCHDOG) begin
            $display("watchdog expired");
            $display("testbench NOT OK");
            $finish;
        end
    end

    // receiver: random stall per word, plus a long hold-off on request
    initial begin
        int gap;
        m_ready = 1'b0;
        @(posedge clk iff rst_n);
        forever begin
            if (long_stall) begin
                m_ready <= 1'b0;
                repeat (40) @(posedge clk);
                long_stall = 1'b0;
            end
            gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 6);
            if (gap > 0) begin
                m_ready <= 1'b0;
                repeat (gap) @(posedge clk);
            end
            m_ready <= 1'b1;
            @(posedge clk iff m_valid);
        end
    end

    task automatic send(input logic [7:0] op, input logic [7:0] ra, input logic [7:0] rb,
                        input logic [31:0] imm, input logic [7:0] tb,
                        input logic [15:0] tof, input bit no_gap);
        int gap;
        gap = no_gap ? 0 : $urandom_range(0, 6);
        if (gap > 0) begin
            s_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        s_valid <= 1'b1;
        s_data  <= {tof, tb, imm, rb, ra, op};
        @(posedge clk iff s_ready);
        words_sent++;
    endtask

    task automatic settle();
        s_valid <= 1'b0;
        @(posedge clk);
        while (pending != 0) @(posedge clk);
        repeat (4) @(posedge clk);
    endtask

    task automatic write_bank(input logic [7:0] bank);
        settle();
        cfg_we    <= 1'b1;
        cfg_wdata <= bank;
        @(posedge clk);
        cfg_we    <= 1'b0;
    endtask

    function automatic logic [7:0] pick_op();
        logic [7:0] ops [30] = '{bcx_pkg::OP_MOV32, bcx_pkg::OP_LD8, bcx_pkg::OP_LD16,
            bcx_pkg::OP_LD32, bcx_pkg::OP_ADD, bcx_pkg::OP_SUB, bcx_pkg::OP_MUL,
            bcx_pkg::OP_JMP, bcx_pkg::OP_BEQ, bcx_pkg::OP_BNE, bcx_pkg::OP_BLT,
            bcx_pkg::OP_BGT, bcx_pkg::OP_PUSH, bcx_pkg::OP_POP, bcx_pkg::OP_LDR,
            bcx_pkg::OP_CALL, bcx_pkg::OP_RET, bcx_pkg::OP_MOVR, bcx_pkg::OP_SHL,
            bcx_pkg::OP_SHR, bcx_pkg::OP_AND, bcx_pkg::OP_OR, bcx_pkg::OP_XOR,
            bcx_pkg::OP_SUBI, bcx_pkg::OP_ADDI, bcx_pkg::OP_BEQI, bcx_pkg::OP_BNEI,
            bcx_pkg::OP_BLTI, bcx_pkg::OP_BGTI, bcx_pkg::OP_NOP};
        int r;
        r = $urandom_range(0, 199);
        if (r == 0) return bcx_pkg::OP_HALT;
        if (r == 1) return 8'($urandom_range(0, 255));   // mostly undefined codes
        return ops[$urandom_range(0, 29)];
    endfunction

    // random register numbers favor a small set so results feed each other
    function automatic logic [7:0] pick_reg();
        return ($urandom_range(0, 3) != 0) ? 8'($urandom_range(0, 7)) :
                                             8'($urandom_range(0, 255));
    endfunction

    function automatic logic [31:0] pick_imm();
        case ($urandom_range(0, 3))
            0: return 32'($urandom_range(0, 40));
            1: return 32'hffff_ffff - $urandom_range(0, 3);
            default: return $urandom;
        endcase
    endfunction

    initial begin
        logic [7:0] banks [4] = '{8'h00, 8'hff, 8'h7f, 8'h35};
        rst_n = 1'b0; cfg_we = 1'b0; cfg_wdata = '0;
        s_valid = 1'b0; s_data = '0;
        long_stall = 1'b0; words_sent = 0;
        repeat (11) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // directed: extremes, bank crossing, stack edges, shifts, call/ret
        send(bcx_pkg::OP_MOV32, 8'h00, 8'h01, 32'hffff_ffff, 8'h00, 16'h0000, 0);
        send(bcx_pkg::OP_MOV32, 8'h00, 8'h02, 32'h0000_0001, 8'h00, 16'h0000, 0);
        send(bcx_pkg::OP_ADD,   8'h01, 8'h02, 32'h0, 8'h00, 16'h0, 0);      // wraps to 0
        send(bcx_pkg::OP_SUB,   8'h01, 8'h02, 32'h0, 8'h00, 16'h0, 0);
        send(bcx_pkg::OP_MUL,   8'h01, 8'h01, 32'h0, 8'h00, 16'h0, 0);
        send(bcx_pkg::OP_LD32,  8'hff, 8'hff, 32'hffff_ffa5, 8'hff, 16'hffff, 0);
        send(bcx_pkg::OP_LDR,   8'h01, 8'h00, 32'h0, 8'h00, 16'h0000, 0);
        send(bcx_pkg::OP_POP,   8'h03, 8'h00, 32'h0, 8'h00, 16'h0, 0);      // empty stack
        send(bcx_pkg::OP_PUSH,  8'h00, 8'h00, 32'h1234_5678, 8'h00, 16'h0, 0);
        send(bcx_pkg::OP_POP,   8'h03, 8'h00, 32'h0, 8'h00, 16'h0, 0);
        send(bcx_pkg::OP_MOV32, 8'h00, 8'h04, 32'd31, 8'h00, 16'h0, 0);
        send(bcx_pkg::OP_SHL,   8'h04, 8'h00, 32'h0, 8'h00, 16'h0, 0);
        send(bcx_pkg::OP_SHR,   8'h04, 8'h00, 32'h0, 8'h00, 16'h0, 0);      // shift by 32 or more
        send(bcx_pkg::OP_JMP,   8'h00, 8'h00, 32'h0, 8'hf0, 16'hfffe, 0);
        send(bcx_pkg::OP_BNEI,  8'h00, 8'h00, 32'h0, 8'h11, 16'h2222, 0);   // crosses bank boundary
        send(bcx_pkg::OP_CALL,  8'h00, 8'h00, 32'h0, 8'hff, 16'hfffd, 0);
        send(bcx_pkg::OP_NOP,   8'h00, 8'h00, 32'h0, 8'h00, 16'h0, 0);
        send(bcx_pkg::OP_NOP,   8'h00, 8'h00, 32'h0, 8'h00, 16'h0, 0);
        send(bcx_pkg::OP_NOP,   8'h00, 8'h00, 32'h0, 8'h00, 16'h0, 0);       // bank wraps to 0
        send(bcx_pkg::OP_RET,   8'h00, 8'h00, 32'h0, 8'h00, 16'h0, 0);
        send(bcx_pkg::OP_BGT,   8'h01, 8'h02, 32'h0, 8'haa, 16'h5555, 0);
        send(bcx_pkg::OP_BLTI,  8'h02, 8'h00, 32'hffff_ffff, 8'h55, 16'haaaa, 0);
        send(bcx_pkg::OP_HALT,  8'h00, 8'h00, 32'h0, 8'h00, 16'h0, 0);
        send(bcx_pkg::OP_ADD,   8'h01, 8'h01, 32'h0, 8'h00, 16'h0, 0);       // ignored while stopped
        write_bank(8'hff);
        send(8'h01,             8'h00, 8'h00, 32'h0, 8'h00, 16'h0, 0);       // undefined code
        send(bcx_pkg::OP_NOP,   8'h00, 8'h00, 32'h0, 8'h00, 16'h0, 0);
        write_bank(8'h00);

        // stack full: 257 pushes back to back, the last one faults; then two pops
        for (int k = 0; k < 257; k++)
            send(bcx_pkg::OP_PUSH, 8'h00, 8'h00, $urandom, 8'h00, 16'h0, 1);
        for (int k = 0; k < 2; k++)
            send(bcx_pkg::OP_POP, pick_reg(), 8'h00, 32'h0, 8'h00, 16'h0, 1);

        // random phases, each under its own start bank
        for (int ph = 0; ph < 4; ph++) begin
            write_bank(banks[ph]);
            if (ph == 1) long_stall = 1'b1;   // block fills and stalls its input
            for (int k = 0; k < 80; k++) begin
                send(pick_op(), pick_reg(), pick_reg(), pick_imm(),
                     8'($urandom_range(0, 255)), 16'($urandom_range(0, 65535)),
                     (ph == 1) && (k < 40));
                if (k == 40) settle();        // pause until results are all in
            end
        end

        settle();
        repeat (20) @(posedge clk);
        $display("sent %0d words, checked %0d results (%0d stores, %0d stack faults)",
                 words_sent, results, stores, faults);
        $display("covered all opcodes, halt and undefined code restarts, stack limits");
        if (errors == 0 && pending == 0)
            $display("testbench OK");
        else
            $display("testbench NOT OK");
        $finish;
    end

endmodule
